// ----- design/burh_pkg.sv -----
// Shared types and codes for the bounded undo/redo history.
package burh_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_UNDO   = 2'd1;
  localparam logic [1:0] OP_REDO   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_UNDO = 2'd1;
  localparam logic [1:0] ST_NO_REDO = 2'd2;

  localparam int unsigned CapWidth = 6;
  localparam int unsigned CntWidth = 6;
  localparam int unsigned OutWidth = 32;
  localparam logic [CapWidth-1:0] CapReset = 6'd20;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic exec;      // run the accepted item on the history
    logic load_out;  // move the staged result into the output register
  } cmd_t;

endpackage

// ----- design/burh_ctrl.sv -----
// Controller: input acceptance, result hand-off and output valid.
module burh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output burh_pkg::cmd_t cmd_o
);

  burh_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= burh_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    cmd_o.exec     = 1'b0;
    cmd_o.load_out = 1'b0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      burh_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = burh_pkg::S_RESP;
        end
      end
      burh_pkg::S_RESP: begin
        // hold the staged result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = burh_pkg::S_IDLE;
        end
      end
      default: state_d = burh_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/burh_dp.sv -----
// Datapath: ring pointers, counts, entry memory and the output register.
module burh_dp #(
  parameter int unsigned MAX_DEPTH  = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  burh_pkg::cmd_t                   cmd_i,
  input  logic [1:0]                       opcode_i,
  input  logic [burh_pkg::OutWidth-1:0]    action_word_i,
  input  logic [burh_pkg::CapWidth-1:0]    capacity_i,
  output logic [1:0]                       status_o,
  output logic [burh_pkg::OutWidth-1:0]    returned_action_o,
  output logic [burh_pkg::CntWidth-1:0]    undo_depth_o,
  output logic [burh_pkg::CntWidth-1:0]    redo_depth_o
);

  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned KW = (CW > burh_pkg::CapWidth) ? CW : burh_pkg::CapWidth;
  localparam int unsigned WW = (DATA_WIDTH > burh_pkg::OutWidth) ? DATA_WIDTH
                                                                 : burh_pkg::OutWidth;
  localparam logic [CW:0] DepthS = (CW + 1)'(MAX_DEPTH);
  localparam logic [KW-1:0] DepthK = KW'(MAX_DEPTH);

  logic [DATA_WIDTH-1:0] mem [MAX_DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] und_q, und_d;
  logic [CW-1:0] tot_q, tot_d;

  logic [1:0]    stat_q, stat_d;
  logic          rsel_q, rsel_d;

  logic [1:0]                    status_q;
  logic [burh_pkg::OutWidth-1:0] ret_q;
  logic [burh_pkg::CntWidth-1:0] udep_q, rdep_q;

  logic [KW-1:0] cap_k;
  logic [CW-1:0] cap;
  logic [CW-1:0] drop;
  logic [CW-1:0] rd_off;
  logic [AW-1:0] addr;
  logic          wr_en, rd_en;
  logic [WW-1:0] word_ext, rdata_ext;
  logic [KW-1:0] und_k, redo_k;

  function automatic logic [AW-1:0] ring(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(base) + (CW + 1)'(off);
    if (s >= DepthS) s = s - DepthS;
    return AW'(s);
  endfunction

  // effective capacity: zero acts as one, saturate at the ring depth
  always_comb begin
    cap_k = KW'(capacity_i);
    if (cap_k == '0) cap_k = KW'(1);
    if (cap_k > DepthK) cap_k = DepthK;
    cap = CW'(cap_k);
  end

  assign drop = und_q - cap + CW'(1);

  always_comb begin
    oldest_d = oldest_q;
    und_d    = und_q;
    tot_d    = tot_q;
    stat_d   = burh_pkg::ST_OK;
    rsel_d   = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_off   = und_q;
    unique case (opcode_i)
      burh_pkg::OP_INSERT: begin
        wr_en = cmd_i.exec;
        if (und_q >= cap) begin
          oldest_d = ring(oldest_q, drop);
          und_d    = cap;
        end else begin
          und_d = und_q + CW'(1);
        end
        tot_d = und_d;
      end
      burh_pkg::OP_UNDO: begin
        rd_off = und_q - CW'(1);
        if (und_q == '0) begin
          stat_d = burh_pkg::ST_NO_UNDO;
        end else begin
          rd_en  = cmd_i.exec;
          rsel_d = 1'b1;
          und_d  = und_q - CW'(1);
        end
      end
      burh_pkg::OP_REDO: begin
        if (tot_q <= und_q) begin
          stat_d = burh_pkg::ST_NO_REDO;
        end else begin
          rd_en  = cmd_i.exec;
          rsel_d = 1'b1;
          und_d  = und_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // the slot after the newest undoable one is also where an insert lands
  assign addr     = ring(oldest_q, rd_off);
  assign word_ext = WW'(action_word_i);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[addr] <= word_ext[DATA_WIDTH-1:0];
    if (rd_en) rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      und_q    <= '0;
      tot_q    <= '0;
    end else if (cmd_i.exec) begin
      oldest_q <= oldest_d;
      und_q    <= und_d;
      tot_q    <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      stat_q <= stat_d;
      rsel_q <= rsel_d;
    end
  end

  assign rdata_ext = WW'(rdata_q);
  assign und_k     = KW'(und_q);
  assign redo_k    = KW'(tot_q) - KW'(und_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_q <= stat_q;
      ret_q    <= rsel_q ? rdata_ext[burh_pkg::OutWidth-1:0] : '0;
      udep_q   <= und_k[burh_pkg::CntWidth-1:0];
      rdep_q   <= redo_k[burh_pkg::CntWidth-1:0];
    end
  end

  assign status_o          = status_q;
  assign returned_action_o = ret_q;
  assign undo_depth_o      = udep_q;
  assign redo_depth_o      = rdep_q;

endmodule

// ----- design/bounded_undo_redo_history.sv -----
// Top level of the bounded undo/redo history with its register port.
//
// Input stream: tuser carries the opcode (insert, undo, redo), tdata the
// action word. Output stream: tuser carries the status, tdata the returned
// action and the undo and redo depths after the step.
// Each item is handled in the idle state, which updates the pointers and
// writes or reads the entry memory, then in the response state, which moves
// the result into the output register. The next input item is taken in the
// cycle after the previous result moved into the output register; the
// response state waits for the registered read of the entry memory and takes
// no new input item until its result has moved into the output register.
// A result waits in the output register while the receiver stalls, and the
// next item is still taken; its result is held until the register frees.
// Reset empties the history (pointers and counts cleared, no memory sweep) and sets
// the capacity register to 20, which sits at byte address 0 of the register port.
// The user must write it only while the block idles; the block does not enforce it.
module bounded_undo_redo_history #(
  parameter int unsigned MAX_DEPTH  = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] action_word
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [31:0] returned_action, [37:32] undo_depth,
                                        // [43:38] redo_depth, [47:44] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [burh_pkg::CapWidth-1:0] cap_q;
  logic                          cap_sel;
  burh_pkg::cmd_t                cmd;
  logic [1:0]                    status;
  logic [31:0]                   ret;
  logic [burh_pkg::CntWidth-1:0] udep, rdep;

  assign pready  = 1'b1;
  assign cap_sel = (paddr[2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= burh_pkg::CapReset;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      cap_q <= pwdata[burh_pkg::CapWidth-1:0];
    end
  end

  assign prdata = cap_sel ? {26'd0, cap_q} : 32'd0;

  burh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .cmd_o       (cmd)
  );

  burh_dp #(
    .MAX_DEPTH  (MAX_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .opcode_i          (s_axis_tuser_i),
    .action_word_i     (s_axis_tdata_i),
    .capacity_i        (cap_q),
    .status_o          (status),
    .returned_action_o (ret),
    .undo_depth_o      (udep),
    .redo_depth_o      (rdep)
  );

  assign m_axis_tdata_o = {4'd0, rdep, udep, ret};
  assign m_axis_tuser_o = status;

endmodule
